// ===== rtl/hafs_pkg.sv =====
`default_nettype none

package hafs_pkg;

  // fixed field widths
  localparam int HANDLE_W = 9;
  localparam int ADDR_W   = 64;
  localparam int STATUS_W = 2;

  // default table depth
  localparam int DEFAULT_CAPACITY = 256;

  // stream packing
  localparam int IN_DATA_W  = 80;  // request_empty, granted_address, release_handle, pad
  localparam int OUT_DATA_W = 80;  // handle_out, address_out, pad

  // operation codes
  localparam logic CMD_ALLOC   = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OOM     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_INVALID = 2'd2;

  // controller to datapath commands
  typedef struct packed {
    logic accept;  // capture item and launch memory reads
    logic commit;  // update tables and load the result register
  } hafs_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic out_free;  // result register can take a new result this cycle
  } hafs_stat_t;

endpackage

`default_nettype wire

// ===== rtl/hafs_ctrl.sv =====
`default_nettype none

module hafs_ctrl
  import hafs_pkg::*;
(
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        in_valid_i,
  output logic       in_ready_o,
  input  wire hafs_stat_t stat_i,
  output hafs_cmd_t  cmd_o
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  state_e state_q;
  logic   ready_q;

  // command decode
  always_comb begin
    cmd_o.accept = in_valid_i && ready_q;
    cmd_o.commit = (state_q == S_EXEC) && stat_i.out_free;
  end

  assign in_ready_o = ready_q;

  // state and registered ready
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ready_q <= 1'b1;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_valid_i && ready_q) begin
            state_q <= S_EXEC;
            ready_q <= 1'b0;
          end
        end
        S_EXEC: begin
          if (stat_i.out_free) begin
            state_q <= S_IDLE;
            ready_q <= 1'b1;
          end
        end
        default: begin
          state_q <= S_IDLE;
          ready_q <= 1'b1;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/hafs_dp.sv =====
`default_nettype none

module hafs_dp
  import hafs_pkg::*;
#(
  parameter int CAPACITY = DEFAULT_CAPACITY
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire hafs_cmd_t      cmd_i,
  output hafs_stat_t          stat_o,
  input  wire                 cmd_in_i,
  input  wire                 request_empty_i,
  input  wire  [ADDR_W-1:0]   granted_address_i,
  input  wire  [HANDLE_W-1:0] release_handle_i,
  output logic                out_valid_o,
  input  wire                 out_ready_i,
  output logic [STATUS_W-1:0] status_o,
  output logic [HANDLE_W-1:0] handle_out_o,
  output logic [ADDR_W-1:0]   address_out_o
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CMP_W = (CNT_W > HANDLE_W) ? CNT_W : HANDLE_W;

  // handle table and free stack
  logic [ADDR_W-1:0] table_mem [CAPACITY];
  logic [CNT_W-1:0]  stack_mem [CAPACITY];

  // counters
  logic [CNT_W-1:0] entry_cnt_q, entry_cnt_d;
  logic [CNT_W-1:0] free_cnt_q, free_cnt_d;

  // captured item and read data
  logic                cmd_q;
  logic                empty_q;
  logic [ADDR_W-1:0]   gaddr_q;
  logic [HANDLE_W-1:0] rhandle_q;
  logic [ADDR_W-1:0]   table_rd_q;
  logic [CNT_W-1:0]    stack_rd_q;

  // result register
  logic                out_valid_q;
  logic [STATUS_W-1:0] status_q;
  logic [HANDLE_W-1:0] handle_q;
  logic [ADDR_W-1:0]   addr_q;

  // commit decisions
  logic [STATUS_W-1:0] res_status;
  logic [HANDLE_W-1:0] res_handle;
  logic [ADDR_W-1:0]   res_addr;
  logic                tbl_we;
  logic [IDX_W-1:0]    tbl_waddr;
  logic [ADDR_W-1:0]   tbl_wdata;
  logic                stk_we;

  logic [IDX_W-1:0] table_raddr;
  logic [IDX_W-1:0] stack_raddr;

  assign table_raddr = IDX_W'(CMP_W'(release_handle_i) - CMP_W'(1));
  assign stack_raddr = IDX_W'(free_cnt_q - CNT_W'(1));

  assign stat_o.out_free = !out_valid_q || out_ready_i;

  // allocate / release decision
  always_comb begin
    res_status  = ST_OK;
    res_handle  = '0;
    res_addr    = '0;
    tbl_we      = 1'b0;
    tbl_waddr   = IDX_W'(entry_cnt_q);
    tbl_wdata   = gaddr_q;
    stk_we      = 1'b0;
    entry_cnt_d = entry_cnt_q;
    free_cnt_d  = free_cnt_q;
    if (cmd_q == CMD_ALLOC) begin
      if (empty_q) begin
        res_status = ST_OK;
      end else if (gaddr_q == '0) begin
        res_status = ST_OOM;
      end else if (free_cnt_q != '0) begin
        // reuse the most recently released handle
        free_cnt_d = free_cnt_q - CNT_W'(1);
        if ((stack_rd_q != '0) && (stack_rd_q <= CNT_W'(CAPACITY))) begin
          tbl_we     = 1'b1;
          tbl_waddr  = IDX_W'(stack_rd_q - CNT_W'(1));
          res_handle = HANDLE_W'(stack_rd_q);
          res_addr   = gaddr_q;
        end else begin
          res_status = ST_OOM;
          res_addr   = gaddr_q;
        end
      end else if (entry_cnt_q == CNT_W'(CAPACITY)) begin
        // table full: hand the address back so it can be freed
        res_status = ST_OOM;
        res_addr   = gaddr_q;
      end else begin
        tbl_we      = 1'b1;
        entry_cnt_d = entry_cnt_q + CNT_W'(1);
        res_handle  = HANDLE_W'(entry_cnt_q + CNT_W'(1));
        res_addr    = gaddr_q;
      end
    end else begin
      tbl_waddr = IDX_W'(CMP_W'(rhandle_q) - CMP_W'(1));
      tbl_wdata = '0;
      if (rhandle_q == '0) begin
        res_status = ST_OK;
      end else if (CMP_W'(rhandle_q) > CMP_W'(entry_cnt_q)) begin
        res_status = ST_INVALID;
      end else if ((table_rd_q == '0) || (free_cnt_q == CNT_W'(CAPACITY))) begin
        res_status = ST_INVALID;
      end else begin
        tbl_we     = 1'b1;
        stk_we     = 1'b1;
        free_cnt_d = free_cnt_q + CNT_W'(1);
        res_addr   = table_rd_q;
      end
    end
  end

  // memories and capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      cmd_q      <= cmd_in_i;
      empty_q    <= request_empty_i;
      gaddr_q    <= granted_address_i;
      rhandle_q  <= release_handle_i;
      table_rd_q <= table_mem[table_raddr];
      stack_rd_q <= stack_mem[stack_raddr];
    end
    if (cmd_i.commit && tbl_we) begin
      table_mem[tbl_waddr] <= tbl_wdata;
    end
    if (cmd_i.commit && stk_we) begin
      stack_mem[IDX_W'(free_cnt_q)] <= CNT_W'(rhandle_q);
    end
  end

  // counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_cnt_q <= '0;
      free_cnt_q  <= '0;
    end else if (cmd_i.commit) begin
      entry_cnt_q <= entry_cnt_d;
      free_cnt_q  <= free_cnt_d;
    end
  end

  // result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      status_q <= res_status;
      handle_q <= res_handle;
      addr_q   <= res_addr;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign handle_out_o  = handle_q;
  assign address_out_o = addr_q;

endmodule

`default_nettype wire

// ===== rtl/handle_allocator_free_stack_top.sv =====
// channel   | dir | tdata (low bit up)                                   | tuser
// ----------+-----+------------------------------------------------------+-------------
// s_axis    | in  | request_empty[0], granted_address[64:1],             | cmd[0]
//           |     | release_handle[73:65], zero pad to 80                |
// m_axis    | out | handle_out[8:0], address_out[72:9], zero pad to 80   | status[1:0]
//
// each transaction is first captured while the handle table and free stack are read (registered
// memory reads), then the tables are updated and the result register is loaded. a new
// transaction is taken only after the current one has loaded the result register.
// reset clears both counters; the memories need no clearing since only written
// entries are ever used. a stalled m_axis holds the block in its update cycle.
`default_nettype none

module handle_allocator_free_stack_top
  import hafs_pkg::*;
#(
  parameter int CAPACITY = DEFAULT_CAPACITY
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   s_axis_tvalid,
  output logic                  s_axis_tready,
  input  wire  [IN_DATA_W-1:0]  s_axis_tdata,   // request_empty, granted_address, release_handle
  input  wire                   s_axis_tuser,   // cmd
  output logic                  m_axis_tvalid,
  input  wire                   m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // handle_out, address_out
  output logic [STATUS_W-1:0]   m_axis_tuser    // status
);

  hafs_cmd_t  cmd;
  hafs_stat_t stat;

  logic [HANDLE_W-1:0] handle_out;
  logic [ADDR_W-1:0]   address_out;

  // sequencing
  hafs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // tables, counters and result register
  hafs_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .cmd_in_i          (s_axis_tuser),
    .request_empty_i   (s_axis_tdata[0]),
    .granted_address_i (s_axis_tdata[ADDR_W:1]),
    .release_handle_i  (s_axis_tdata[ADDR_W+HANDLE_W:ADDR_W+1]),
    .out_valid_o       (m_axis_tvalid),
    .out_ready_i       (m_axis_tready),
    .status_o          (m_axis_tuser),
    .handle_out_o      (handle_out),
    .address_out_o     (address_out)
  );

  // output packing
  assign m_axis_tdata = {{(OUT_DATA_W - HANDLE_W - ADDR_W){1'b0}}, address_out, handle_out};

endmodule

`default_nettype wire
